>>> rtl/saos_pkg.sv
// Shared constants, types and codes of the obstacle steering block.
package saos_pkg;

	localparam int SAMPLE_BITS  = 10;
	localparam int LEVEL_W      = 10;
	localparam int FRONT_WINDOW = 128;
	localparam int LEFT_WINDOW  = 16;
	localparam int RIGHT_WINDOW = 16;

	localparam int FRONT_AW = $clog2(FRONT_WINDOW);
	localparam int LEFT_AW  = $clog2(LEFT_WINDOW);
	localparam int RIGHT_AW = $clog2(RIGHT_WINDOW);

	localparam int SUM_W     = 24;
	localparam int OPW       = SUM_W + 1;
	localparam int ALU_W     = SUM_W + 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEVEL_W-1:0] ENTER_RST = LEVEL_W'(150);
	localparam logic [LEVEL_W-1:0] LEAVE_RST = LEVEL_W'(60);
	localparam logic [LEVEL_W-1:0] LEFT_RST  = LEVEL_W'(40);
	localparam logic [LEVEL_W-1:0] RIGHT_RST = LEVEL_W'(40);

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [OPW-1:0]   opnd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTER = 2'd0,
		REG_LEAVE = 2'd1,
		REG_LEFT  = 2'd2,
		REG_RIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_FWD   = 2'd0,
		DIR_BACK  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRONT,
		ST_LEFT,
		ST_RIGHT,
		ST_CMP_F,
		ST_CMP_S,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic out_valid;
		logic load;
		logic upd_front;
		logic upd_left;
		logic upd_right;
		logic cmp_front;
		logic cmp_side;
	} ctrl_t;

endpackage

>>> rtl/saos_in_if.sv
// Request channel carrying one set of distance samples and the steering inputs.
interface saos_in_if;
	import saos_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] front_sample;
	logic [SAMPLE_BITS-1:0] left_sample;
	logic [SAMPLE_BITS-1:0] right_sample;
	logic [1:0]             current_direction;
	logic                   steer_enable;

	modport source (
		output valid, front_sample, left_sample, right_sample, current_direction, steer_enable,
		input  ready
	);

	modport sink (
		input  valid, front_sample, left_sample, right_sample, current_direction, steer_enable,
		output ready
	);
endinterface

>>> rtl/saos_out_if.sv
// Result channel carrying the chosen direction and the three running sums.
interface saos_out_if;
	import saos_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       next_direction;
	logic             direction_changed;
	sum_t             front_total;
	sum_t             left_total;
	sum_t             right_total;

	modport source (
		output valid, next_direction, direction_changed, front_total, left_total, right_total,
		input  ready
	);

	modport sink (
		input  valid, next_direction, direction_changed, front_total, left_total, right_total,
		output ready
	);
endinterface

>>> rtl/saos_ram.sv
// Generic single-port-write RAM with registered read.
module saos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/saos_alu.sv
// Shared add/subtract unit: a - b + c with saturation and a sign test.
module saos_alu (
	input  saos_pkg::opnd_t a,
	input  saos_pkg::opnd_t b,
	input  saos_pkg::opnd_t c,
	output saos_pkg::sum_t  sat,
	output logic            gt
);
	import saos_pkg::*;

	localparam logic signed [ALU_W-1:0] HI = {{(ALU_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
	localparam logic signed [ALU_W-1:0] LO = {{(ALU_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

	logic signed [ALU_W-1:0] t;

	always_comb begin
		t = {{(ALU_W-OPW){a[OPW-1]}}, a} - {{(ALU_W-OPW){b[OPW-1]}}, b}
			+ {{(ALU_W-OPW){c[OPW-1]}}, c};
		if (t > HI) begin
			sat = HI[SUM_W-1:0];
		end else if (t < LO) begin
			sat = LO[SUM_W-1:0];
		end else begin
			sat = t[SUM_W-1:0];
		end
		gt = !t[ALU_W-1] && (t != '0);
	end
endmodule

>>> rtl/saos_ctrl.sv
// Sequencer stepping one request through update, compare and result phases.
module saos_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	output saos_pkg::ctrl_t ctl
);
	import saos_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_FRONT;
			ST_FRONT: state_d = ST_LEFT;
			ST_LEFT:  state_d = ST_RIGHT;
			ST_RIGHT: state_d = ST_CMP_F;
			ST_CMP_F: state_d = ST_CMP_S;
			ST_CMP_S: state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.in_ready = 1'b1;
				ctl.load     = in_valid;
			end
			ST_FRONT: ctl.upd_front = 1'b1;
			ST_LEFT:  ctl.upd_left  = 1'b1;
			ST_RIGHT: ctl.upd_right = 1'b1;
			ST_CMP_F: ctl.cmp_front = 1'b1;
			ST_CMP_S: ctl.cmp_side  = 1'b1;
			ST_OUT:   ctl.out_valid = 1'b1;
			default:  ctl = '0;
		endcase
	end
endmodule

>>> rtl/sensor_average_obstacle_steering_unit.sv
// Top level: boxcar averages of three distance sensors and hysteretic steering choice.
//
//   channel  dir  handshake          carries
//   in_ch    in   valid/ready        front/left/right sample, current_direction, steer_enable
//   out_ch   out  valid/ready        next_direction, direction_changed, three running sums
//   cfg      in   cfg_we only        cfg_idx selects a threshold, cfg_data is its new value
//
// One request passes through three sum update steps and two compare steps, all through
// the single shared add/saturate unit; then the result waits in its registers until taken,
// and the block returns to idle before it can accept the next request.
// in_ch.ready is high only while idle; a stalled result simply holds the block in its
// result phase. Reset clears sums, slots and the history valid bits at once, so no
// clearing pass is needed.
module sensor_average_obstacle_steering_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	saos_in_if.sink                             in_ch,
	saos_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [saos_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [saos_pkg::LEVEL_W-1:0]        cfg_data
);
	import saos_pkg::*;

	ctrl_t ctl;

	// thresholds
	logic [LEVEL_W-1:0] enter_q, leave_q, left_lim_q, right_lim_q;

	// latched request
	logic [SAMPLE_BITS-1:0] front_sample_q, left_sample_q, right_sample_q;
	logic                   steer_q;
	dir_t                   cur_q;

	// decision
	dir_t dir_q;
	logic decided_q;

	// ring state
	logic [FRONT_AW-1:0]     front_slot_q;
	logic [LEFT_AW-1:0]      left_slot_q;
	logic [RIGHT_AW-1:0]     right_slot_q;
	sum_t                    front_sum_q, left_sum_q, right_sum_q;
	logic [FRONT_WINDOW-1:0] front_wr_q;
	logic [LEFT_WINDOW-1:0]  left_wr_q;
	logic [RIGHT_WINDOW-1:0] right_wr_q;
	logic [LEVEL_W-1:0]      front_fill_q;

	logic [SAMPLE_BITS-1:0] front_rd, left_rd, right_rd;
	opnd_t                  front_old, left_old, right_old;

	logic [OPW-1:0] enter_t, leave_t, left_t, right_t;

	opnd_t alu_a, alu_b, alu_c;
	sum_t  alu_sat;
	logic  alu_gt;

	logic cur_side;
	logic fill_now;

	saos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl)
	);

	// Histories: read at the oldest slot when the request is taken, written in its update step.
	saos_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRONT_WINDOW)) u_front_ram (
		.clk   (clk),
		.we    (ctl.upd_front),
		.waddr (front_slot_q),
		.wdata (front_sample_q),
		.re    (ctl.load),
		.raddr (front_slot_q),
		.rdata (front_rd)
	);

	saos_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LEFT_WINDOW)) u_left_ram (
		.clk   (clk),
		.we    (ctl.upd_left),
		.waddr (left_slot_q),
		.wdata (left_sample_q),
		.re    (ctl.load),
		.raddr (left_slot_q),
		.rdata (left_rd)
	);

	saos_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RIGHT_WINDOW)) u_right_ram (
		.clk   (clk),
		.we    (ctl.upd_right),
		.waddr (right_slot_q),
		.wdata (right_sample_q),
		.re    (ctl.load),
		.raddr (right_slot_q),
		.rdata (right_rd)
	);

	saos_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.sat (alu_sat),
		.gt  (alu_gt)
	);

	// Configuration writes; unknown indexes have no effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q     <= ENTER_RST;
			leave_q     <= LEAVE_RST;
			left_lim_q  <= LEFT_RST;
			right_lim_q <= RIGHT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ENTER: enter_q     <= cfg_data;
				REG_LEAVE: leave_q     <= cfg_data;
				REG_LEFT:  left_lim_q  <= cfg_data;
				REG_RIGHT: right_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Average tests are done on sums, so scale each threshold by its window.
	assign enter_t = OPW'(enter_q) * OPW'(FRONT_WINDOW);
	assign leave_t = OPW'(leave_q) * OPW'(FRONT_WINDOW);
	assign left_t  = OPW'(left_lim_q) * OPW'(LEFT_WINDOW);
	assign right_t = OPW'(right_lim_q) * OPW'(RIGHT_WINDOW);

	// Front entries unwritten since reset or a fill read as the fill value; side ones as zero.
	assign front_old = front_wr_q[front_slot_q] ? opnd_t'(front_rd) : opnd_t'(front_fill_q);
	assign left_old  = left_wr_q[left_slot_q]   ? opnd_t'(left_rd)  : '0;
	assign right_old = right_wr_q[right_slot_q] ? opnd_t'(right_rd) : '0;

	assign cur_side = (cur_q == DIR_LEFT) || (cur_q == DIR_RIGHT);

	// Steer the shared unit's operands by phase.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_c = '0;
		if (ctl.upd_front) begin
			alu_a = opnd_t'(front_sum_q);
			alu_b = front_old;
			alu_c = opnd_t'(front_sample_q);
		end else if (ctl.upd_left) begin
			alu_a = opnd_t'(left_sum_q);
			alu_b = left_old;
			alu_c = opnd_t'(left_sample_q);
		end else if (ctl.upd_right) begin
			alu_a = opnd_t'(right_sum_q);
			alu_b = right_old;
			alu_c = opnd_t'(right_sample_q);
		end else if (ctl.cmp_front) begin
			// forward: sum > enter; otherwise: leave > sum
			if (cur_q == DIR_FWD) begin
				alu_a = opnd_t'(front_sum_q);
				alu_b = opnd_t'(enter_t);
			end else begin
				alu_a = opnd_t'(leave_t);
				alu_b = opnd_t'(front_sum_q);
			end
		end else if (ctl.cmp_side) begin
			if (cur_q == DIR_LEFT) begin
				alu_a = opnd_t'(left_sum_q);
				alu_b = opnd_t'(left_t);
			end else begin
				alu_a = opnd_t'(right_sum_q);
				alu_b = opnd_t'(right_t);
			end
		end
	end

	assign fill_now = ctl.cmp_front && steer_q && alu_gt && ((cur_q == DIR_FWD) || cur_side);

	// Latch the request.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			front_sample_q <= in_ch.front_sample;
			left_sample_q  <= in_ch.left_sample;
			right_sample_q <= in_ch.right_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_q   <= 1'b0;
			cur_q     <= DIR_FWD;
			dir_q     <= DIR_FWD;
			decided_q <= 1'b0;
		end else if (ctl.load) begin
			steer_q   <= in_ch.steer_enable;
			cur_q     <= dir_t'(in_ch.current_direction);
			dir_q     <= dir_t'(in_ch.current_direction);
			decided_q <= 1'b0;
		end else if (ctl.cmp_front) begin
			// front hysteresis takes priority over the side limits
			if (fill_now) begin
				dir_q     <= (cur_q == DIR_FWD) ? DIR_RIGHT : DIR_FWD;
				decided_q <= 1'b1;
			end
		end else if (ctl.cmp_side) begin
			if (steer_q && !decided_q && alu_gt) begin
				if (cur_q == DIR_LEFT) begin
					dir_q <= DIR_RIGHT;
				end else if (cur_q == DIR_RIGHT) begin
					dir_q <= DIR_LEFT;
				end
			end
		end
	end

	// Front ring: update sum, mark the slot written, advance; a fill drops all marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_sum_q  <= '0;
			front_slot_q <= '0;
			front_wr_q   <= '0;
			front_fill_q <= '0;
		end else if (ctl.upd_front) begin
			front_sum_q              <= alu_sat;
			front_wr_q[front_slot_q] <= 1'b1;
			front_slot_q <= (front_slot_q == FRONT_AW'(FRONT_WINDOW - 1)) ? '0
				: front_slot_q + FRONT_AW'(1);
		end else if (fill_now) begin
			front_wr_q   <= '0;
			front_fill_q <= (cur_q == DIR_FWD) ? enter_q : leave_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q  <= '0;
			left_slot_q <= '0;
			left_wr_q   <= '0;
		end else if (ctl.upd_left) begin
			left_sum_q             <= alu_sat;
			left_wr_q[left_slot_q] <= 1'b1;
			left_slot_q <= (left_slot_q == LEFT_AW'(LEFT_WINDOW - 1)) ? '0
				: left_slot_q + LEFT_AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_sum_q  <= '0;
			right_slot_q <= '0;
			right_wr_q   <= '0;
		end else if (ctl.upd_right) begin
			right_sum_q              <= alu_sat;
			right_wr_q[right_slot_q] <= 1'b1;
			right_slot_q <= (right_slot_q == RIGHT_AW'(RIGHT_WINDOW - 1)) ? '0
				: right_slot_q + RIGHT_AW'(1);
		end
	end

	// Handshakes and result payload straight from the registers.
	assign in_ch.ready              = ctl.in_ready;
	assign out_ch.valid             = ctl.out_valid;
	assign out_ch.next_direction    = dir_q;
	assign out_ch.direction_changed = (dir_q != cur_q);
	assign out_ch.front_total       = front_sum_q;
	assign out_ch.left_total        = left_sum_q;
	assign out_ch.right_total       = right_sum_q;

	// Never take a request while a result is being offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("request accepted while result pending");

	// A front fill leaves every front entry reading as the fill level.
	a_fill_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fill_now |=> (front_wr_q == '0))
		else $error("front fill did not drop history marks");

	// The front sum moves only in its own update step.
	a_front_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.upd_front |=> $stable(front_sum_q))
		else $error("front sum changed outside its update");

	// Backward is never left by the decision.
	a_back_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (cur_q == DIR_BACK)) |-> (dir_q == DIR_BACK))
		else $error("backward direction was changed");
endmodule
